// ----- src/buoyant_sphere_motion_step_macros.svh -----
// assertion macros for the buoyant sphere motion step block
// expects signals named clk and rst_n in the module that uses them
`ifndef BUOYANT_SPHERE_MOTION_STEP_MACROS_SVH
`define BUOYANT_SPHERE_MOTION_STEP_MACROS_SVH

// same-cycle implication
`define BSM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsm assertion failed");

// next-cycle implication
`define BSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsm assertion failed");

`endif

// ----- src/bsm_pkg.sv -----
// shared types and constants for the buoyant sphere motion step block
// no dependencies
`default_nettype none

package bsm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int CFG_W     = 26;
  localparam int RAD_W     = 22;
  localparam int DT_W      = 24;
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t ONE_W     = word_t'(1 << FRAC_BITS);
  localparam word_t NEG_ONE_W = -ONE_W;

  // pi and 4/3 pi rescaled from q30, drag factors in q30, 1/3 reciprocal
  localparam logic [17:0] PI_Q          = 18'd205887;
  localparam logic [18:0] FOUR_THIRDS_Q = 19'd274517;
  localparam logic [29:0] DRAG_WATER    = 30'd1070520599;
  localparam logic [29:0] DRAG_AIR      = 30'd1073204953;
  localparam logic [31:0] RECIP3        = 32'hAAAAAAAB;

  typedef enum logic [2:0] {
    REG_WATER_LINE    = 3'd0,
    REG_FLOOR_LINE    = 3'd1,
    REG_RIGHT_WALL    = 3'd2,
    REG_GRAVITY_ACCEL = 3'd3,
    REG_BUOYANCY_GAIN = 3'd4,
    REG_SPHERE_RADIUS = 3'd5,
    REG_START_X       = 3'd6,
    REG_START_Y       = 3'd7
  } reg_idx_t;

  localparam logic [CFG_W-1:0] WATER_LINE_RST = 26'd7864320;
  localparam logic [CFG_W-1:0] FLOOR_LINE_RST = 26'd15728640;
  localparam logic [CFG_W-1:0] RIGHT_WALL_RST = 26'd26214400;
  localparam logic [CFG_W-1:0] GRAVITY_RST    = 26'd642253;
  localparam logic [CFG_W-1:0] BUOYANCY_RST   = 26'd65536;
  localparam logic [RAD_W-1:0] RADIUS_RST     = 22'd655360;
  localparam logic [CFG_W-1:0] START_X_RST    = 26'd13107200;
  localparam logic [CFG_W-1:0] START_Y_RST    = 26'd0;

  typedef struct packed {
    logic [CFG_W-1:0] water_line;
    logic [CFG_W-1:0] floor_line;
    logic [CFG_W-1:0] right_wall;
    logic [CFG_W-1:0] gravity_accel;
    logic [CFG_W-1:0] buoyancy_gain;
    logic [RAD_W-1:0] sphere_radius;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_GV, OP_RR, OP_RRR, OP_FULL, OP_HH, OP_PHH, OP_DIV3,
    OP_CAP, OP_GVOL, OP_DV, OP_DRX, OP_DRY, OP_B6X, OP_B6Y
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic wr;
    logic fin;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/bsm_in_if.sv -----
// input channel of the sphere motion step: one time step per beat
// depends on bsm_pkg
`default_nettype none

interface bsm_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsm_pkg::DT_W-1:0]    time_step;

  modport source (output valid, output time_step, input ready);
  modport sink (input valid, input time_step, output ready);
endinterface

`default_nettype wire

// ----- src/bsm_out_if.sv -----
// result channel of the sphere motion step: new state and impact flag per beat
// depends on bsm_pkg
`default_nettype none

interface bsm_out_if;
  logic           valid;
  logic           ready;
  bsm_pkg::word_t position_x;
  bsm_pkg::word_t position_y;
  bsm_pkg::word_t velocity_x;
  bsm_pkg::word_t velocity_y;
  logic           impact;

  modport source (output valid, output position_x, output position_y,
                  output velocity_x, output velocity_y, output impact, input ready);
  modport sink (input valid, input position_x, input position_y,
                input velocity_x, input velocity_y, input impact, output ready);
endinterface

`default_nettype wire

// ----- src/bsm_mul.sv -----
// shared multi-cycle unsigned multiplier, 48 x 32 bits as two 24 x 32 halves
// depends on bsm_pkg
`default_nettype none

module bsm_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [bsm_pkg::MUL_A_W-1:0]  a,
  input  wire logic [bsm_pkg::MUL_B_W-1:0]  b,
  output logic      [bsm_pkg::PROD_W-1:0]   prod,
  output logic                              done
);
  localparam int HALF = bsm_pkg::MUL_A_W / 2;
  localparam int PP_W = HALF + bsm_pkg::MUL_B_W;

  logic [PP_W-1:0]               plo_r;
  logic [PP_W-1:0]               phi_r;
  logic [HALF-1:0]               ahi_r;
  logic [bsm_pkg::MUL_B_W-1:0]   b_r;
  logic [bsm_pkg::PROD_W-1:0]    prod_r;
  logic                          st1_r, st2_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r  <= 1'b0;
      st2_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st1_r  <= start;
      st2_r  <= st1_r;
      done_r <= st2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      plo_r <= PP_W'(a[HALF-1:0] * b);
      ahi_r <= a[bsm_pkg::MUL_A_W-1:HALF];
      b_r   <= b;
    end
    if (st1_r) begin
      phi_r <= PP_W'(ahi_r * b_r);
    end
    if (st2_r) begin
      prod_r <= {phi_r, {HALF{1'b0}}} + bsm_pkg::PROD_W'(plo_r);
    end
  end

  assign prod = prod_r;
  assign done = done_r;
endmodule

`default_nettype wire

// ----- src/bsm_ctrl.sv -----
// controller: sequences the multiply steps of one time step and the final update
// depends on bsm_pkg and the assertion macro header
`default_nettype none
`include "buoyant_sphere_motion_step_macros.svh"

module bsm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output bsm_pkg::cmd_t      cmd,
  input  wire bsm_pkg::sts_t sts
);
  bsm_pkg::state_t state_r, state_nxt;
  bsm_pkg::op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsm_pkg::ST_IDLE;
      op_r    <= bsm_pkg::OP_GV;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.wr        = 1'b0;
    cmd.fin       = 1'b0;
    cmd.op        = op_r;
    case (state_r)
      bsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = bsm_pkg::OP_GV;
          state_nxt = bsm_pkg::ST_ISSUE;
        end
      end
      bsm_pkg::ST_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_nxt     = bsm_pkg::ST_WAIT;
      end
      bsm_pkg::ST_WAIT: begin
        if (sts.mul_done) begin
          cmd.wr = 1'b1;
          if (op_r == bsm_pkg::OP_B6Y) begin
            state_nxt = bsm_pkg::ST_FIN;
          end else begin
            op_nxt    = bsm_pkg::op_t'(op_r + 4'd1);
            state_nxt = bsm_pkg::ST_ISSUE;
          end
        end
      end
      bsm_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = bsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsm_pkg::ST_IDLE;
      end
    endcase
  end

  `BSM_ASSERT_IMPL(a_done_in_wait, sts.mul_done, state_r == bsm_pkg::ST_WAIT)
  `BSM_ASSERT_NEXT(a_accept_starts, in_valid && in_ready,
                   state_r == bsm_pkg::ST_ISSUE && op_r == bsm_pkg::OP_GV)
  `BSM_ASSERT_NEXT(a_issue_then_wait, state_r == bsm_pkg::ST_ISSUE,
                   state_r == bsm_pkg::ST_WAIT)
endmodule

`default_nettype wire

// ----- src/bsm_datapath.sv -----
// datapath: motion state, step intermediates, shared multiplier and output register
// depends on bsm_pkg and bsm_mul
`default_nettype none

module bsm_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bsm_pkg::cmd_t               cmd,
  output bsm_pkg::sts_t                    sts,
  input  wire bsm_pkg::cfg_t               cfg,
  input  wire logic [bsm_pkg::DT_W-1:0]    in_time_step,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bsm_pkg::word_t                   out_position_x,
  output bsm_pkg::word_t                   out_position_y,
  output bsm_pkg::word_t                   out_velocity_x,
  output bsm_pkg::word_t                   out_velocity_y,
  output logic                             out_impact
);
  function automatic bsm_pkg::word_t sat36(input logic [35:0] v);
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) return v[31:0];
    return v[35] ? 32'h80000000 : 32'h7FFFFFFF;
  endfunction

  function automatic bsm_pkg::word_t sat33(input logic [32:0] v);
    if (v[32] == v[31]) return v[31:0];
    return v[32] ? 32'h80000000 : 32'h7FFFFFFF;
  endfunction

  function automatic logic [31:0] mag(input bsm_pkg::word_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  bsm_pkg::word_t pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  bsm_pkg::word_t vy_r, vxd_r, vyd_r;
  logic [bsm_pkg::DT_W-1:0] dt_r;
  logic [27:0] rr_r, hh_r;
  logic [33:0] rrr_r;
  logic [36:0] full_r, vol_r;
  logic [29:0] phh_r;
  logic [28:0] q3_r;
  logic [46:0] gvol_r;
  logic [31:0] b6x_r, b6y_r;

  bsm_pkg::word_t out_px_r, out_py_r, out_vx_r, out_vy_r;
  logic           out_hit_r, out_valid_r;

  logic [bsm_pkg::MUL_A_W-1:0] mul_a;
  logic [bsm_pkg::MUL_B_W-1:0] mul_b;
  logic [bsm_pkg::PROD_W-1:0]  prod;
  logic                        mul_done;

  // submersion geometry, all against the position before the move
  logic [33:0] ys, rs, ws, yw, ad;
  logic        above, under, deep;
  logic [bsm_pkg::RAD_W-1:0] h;
  logic [23:0] tr;
  logic [36:0] capv, vol_sel;
  logic [29:0] drag_k;
  logic [33:0] dvc;
  logic [31:0] dmag;

  assign ys    = {{2{pos_y_r[31]}}, pos_y_r};
  assign rs    = {12'b0, cfg.sphere_radius};
  assign ws    = {8'b0, cfg.water_line};
  assign yw    = ys - ws;
  assign ad    = yw[33] ? (~yw + 34'd1) : yw;
  assign above = $signed(ys + rs) < $signed(ws);
  assign under = $signed(ys - rs) > $signed(ws);
  assign deep  = $signed(ys) > $signed(ws);
  assign h     = bsm_pkg::RAD_W'(rs - ad);
  assign tr    = 24'(({2'b00, cfg.sphere_radius} << 1) + {2'b00, cfg.sphere_radius}
                     - {2'b00, h});
  assign drag_k = deep ? bsm_pkg::DRAG_WATER : bsm_pkg::DRAG_AIR;

  assign capv = prod[52:16];
  always_comb begin
    if (above) begin
      vol_sel = '0;
    end else if (under) begin
      vol_sel = full_r;
    end else if (deep) begin
      vol_sel = (full_r > capv) ? (full_r - capv) : '0;
    end else begin
      vol_sel = capv;
    end
  end

  // anything past 34 bits saturates the velocity anyway
  assign dvc  = (|prod[79:50]) ? 34'h3FFFFFFFF : prod[49:16];
  assign dmag = prod[61:30];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      bsm_pkg::OP_GV: begin
        mul_a = 48'(cfg.gravity_accel);
        mul_b = 32'(dt_r);
      end
      bsm_pkg::OP_RR: begin
        mul_a = 48'(cfg.sphere_radius);
        mul_b = 32'(cfg.sphere_radius);
      end
      bsm_pkg::OP_RRR: begin
        mul_a = 48'(rr_r);
        mul_b = 32'(cfg.sphere_radius);
      end
      bsm_pkg::OP_FULL: begin
        mul_a = 48'(rrr_r);
        mul_b = 32'(bsm_pkg::FOUR_THIRDS_Q);
      end
      bsm_pkg::OP_HH: begin
        mul_a = 48'(h);
        mul_b = 32'(h);
      end
      bsm_pkg::OP_PHH: begin
        mul_a = 48'(hh_r);
        mul_b = 32'(bsm_pkg::PI_Q);
      end
      bsm_pkg::OP_DIV3: begin
        mul_a = 48'(phh_r);
        mul_b = bsm_pkg::RECIP3;
      end
      bsm_pkg::OP_CAP: begin
        mul_a = 48'(q3_r);
        mul_b = 32'(tr);
      end
      bsm_pkg::OP_GVOL: begin
        mul_a = 48'(vol_r);
        mul_b = 32'(cfg.buoyancy_gain);
      end
      bsm_pkg::OP_DV: begin
        mul_a = 48'(gvol_r);
        mul_b = 32'(dt_r);
      end
      bsm_pkg::OP_DRX: begin
        mul_a = 48'(mag(vel_x_r));
        mul_b = 32'(drag_k);
      end
      bsm_pkg::OP_DRY: begin
        mul_a = 48'(mag(vy_r));
        mul_b = 32'(drag_k);
      end
      bsm_pkg::OP_B6X: begin
        mul_a = 48'(mag(vxd_r));
        mul_b = bsm_pkg::RECIP3;
      end
      bsm_pkg::OP_B6Y: begin
        mul_a = 48'(mag(vyd_r));
        mul_b = bsm_pkg::RECIP3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bsm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r <= in_time_step;
    end
    if (cmd.wr) begin
      case (cmd.op)
        bsm_pkg::OP_GV:   vy_r   <= sat36({{4{vel_y_r[31]}}, vel_y_r} + {1'b0, prod[50:16]});
        bsm_pkg::OP_RR:   rr_r   <= prod[43:16];
        bsm_pkg::OP_RRR:  rrr_r  <= prod[49:16];
        bsm_pkg::OP_FULL: full_r <= prod[52:16];
        bsm_pkg::OP_HH:   hh_r   <= prod[43:16];
        bsm_pkg::OP_PHH:  phh_r  <= prod[45:16];
        bsm_pkg::OP_DIV3: q3_r   <= prod[61:33];
        bsm_pkg::OP_CAP:  vol_r  <= vol_sel;
        bsm_pkg::OP_GVOL: gvol_r <= prod[62:16];
        bsm_pkg::OP_DV:   vy_r   <= sat36({{4{vy_r[31]}}, vy_r} - {2'b00, dvc});
        bsm_pkg::OP_DRX:  vxd_r  <= vel_x_r[31] ? (~dmag + 32'd1) : dmag;
        bsm_pkg::OP_DRY:  vyd_r  <= vy_r[31] ? (~dmag + 32'd1) : dmag;
        bsm_pkg::OP_B6X:  b6x_r  <= prod[65:34];
        bsm_pkg::OP_B6Y:  b6y_r  <= prod[65:34];
        default: begin
        end
      endcase
    end
  end

  // move, then wall and floor clamps
  bsm_pkg::word_t npx, npy, fx, fy, fvx, fvy, bx;
  logic           fhit;

  assign npx = sat33({pos_x_r[31], pos_x_r} + {vxd_r[31], vxd_r});
  assign npy = sat33({pos_y_r[31], pos_y_r} + {vyd_r[31], vyd_r});
  // negated truncating divide by six
  assign bx  = vxd_r[31] ? b6x_r : (~b6x_r + 32'd1);

  always_comb begin
    fx   = npx;
    fvx  = vxd_r;
    fy   = npy;
    fvy  = vyd_r;
    fhit = 1'b0;
    if (npx[31]) begin
      fx   = '0;
      fvx  = bx;
      fhit = $signed(vxd_r) < $signed(bsm_pkg::NEG_ONE_W);
    end else if ($signed(npx) > $signed({6'b0, cfg.right_wall})) begin
      fx   = {6'b0, cfg.right_wall};
      fvx  = bx;
      fhit = $signed(vxd_r) > $signed(bsm_pkg::ONE_W);
    end
    if ($signed(npy) > $signed({6'b0, cfg.floor_line})) begin
      fy   = {6'b0, cfg.floor_line};
      fvy  = ~b6y_r + 32'd1;
      fhit = fhit | ($signed(vyd_r) > $signed(bsm_pkg::ONE_W));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= {6'b0, bsm_pkg::START_X_RST};
      pos_y_r     <= {6'b0, bsm_pkg::START_Y_RST};
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin) begin
        pos_x_r     <= fx;
        pos_y_r     <= fy;
        vel_x_r     <= fvx;
        vel_y_r     <= fvy;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_px_r  <= fx;
      out_py_r  <= fy;
      out_vx_r  <= fvx;
      out_vy_r  <= fvy;
      out_hit_r <= fhit;
    end
  end

  assign sts            = {mul_done, !out_valid_r || out_ready};
  assign out_valid      = out_valid_r;
  assign out_position_x = out_px_r;
  assign out_position_y = out_py_r;
  assign out_velocity_x = out_vx_r;
  assign out_velocity_y = out_vy_r;
  assign out_impact     = out_hit_r;
endmodule

`default_nettype wire

// ----- src/buoyant_sphere_motion_step.sv -----
// Buoyant sphere motion step: each accepted time step advances the sphere's
// position and velocity through gravity, buoyancy, drag, the move and the wall
// and floor bounces, and returns one result beat with the new state and an
// impact flag. A step goes from the accept state through fourteen products
// issued in turn to the single shared two-pass 24x32 multiplier, then to the
// update state. The next step is accepted the cycle after the update while
// the result waits in the output register. Configuration writes are taken at
// any time but should be made while idle.
// depends on bsm_pkg, bsm_in_if, bsm_out_if, bsm_ctrl and bsm_datapath
`default_nettype none

module buoyant_sphere_motion_step (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bsm_in_if.sink                           in_ch,
  bsm_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [bsm_pkg::CFG_W-1:0]   cfg_data
);
  bsm_pkg::cfg_t cfg_r;
  bsm_pkg::cmd_t cmd;
  bsm_pkg::sts_t sts;
  logic          in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.water_line    <= bsm_pkg::WATER_LINE_RST;
      cfg_r.floor_line    <= bsm_pkg::FLOOR_LINE_RST;
      cfg_r.right_wall    <= bsm_pkg::RIGHT_WALL_RST;
      cfg_r.gravity_accel <= bsm_pkg::GRAVITY_RST;
      cfg_r.buoyancy_gain <= bsm_pkg::BUOYANCY_RST;
      cfg_r.sphere_radius <= bsm_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      case (bsm_pkg::reg_idx_t'(cfg_index))
        bsm_pkg::REG_WATER_LINE:    cfg_r.water_line    <= cfg_data;
        bsm_pkg::REG_FLOOR_LINE:    cfg_r.floor_line    <= cfg_data;
        bsm_pkg::REG_RIGHT_WALL:    cfg_r.right_wall    <= cfg_data;
        bsm_pkg::REG_GRAVITY_ACCEL: cfg_r.gravity_accel <= cfg_data;
        bsm_pkg::REG_BUOYANCY_GAIN: cfg_r.buoyancy_gain <= cfg_data;
        bsm_pkg::REG_SPHERE_RADIUS: cfg_r.sphere_radius <= cfg_data[bsm_pkg::RAD_W-1:0];
        // start position only acts at reset, which restores its reset value
        default: begin
        end
      endcase
    end
  end

  bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign in_ch.ready = in_ready;

  bsm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg_r),
    .in_time_step   (in_ch.time_step),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_position_x (out_ch.position_x),
    .out_position_y (out_ch.position_y),
    .out_velocity_x (out_ch.velocity_x),
    .out_velocity_y (out_ch.velocity_y),
    .out_impact     (out_ch.impact)
  );
endmodule

`default_nettype wire

// ----- tb/buoyant_sphere_motion_step_tb.sv -----
// self-checking testbench for buoyant_sphere_motion_step: steps are driven and results checked
// against an in-bench fixed point model of the sphere motion
// depends on bsm_pkg, bsm_in_if, bsm_out_if and the block itself
`default_nettype none

module buoyant_sphere_motion_step_tb;

  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;
  localparam longint unsigned PROD_LIMIT = 64'd1 << 62;
  localparam longint unsigned PI_30 = 64'd3373259426;
  localparam longint unsigned K_WATER = 64'd1070520599;
  localparam longint unsigned K_AIR = 64'd1073204953;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    bsm_pkg::word_t px;
    bsm_pkg::word_t py;
    bsm_pkg::word_t vx;
    bsm_pkg::word_t vy;
    logic           impact;
  } motion_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [bsm_pkg::CFG_W-1:0] cfg_data;

  bsm_in_if in_ch ();
  bsm_out_if out_ch ();

  buoyant_sphere_motion_step DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state and settings; start registers always come back to their reset values
  longint unsigned settings [8];
  longint sphere_x = 64'(bsm_pkg::START_X_RST);
  longint sphere_y = 64'(bsm_pkg::START_Y_RST);
  longint speed_x = 0;
  longint speed_y = 0;

  logic [bsm_pkg::DT_W-1:0] pending_steps [$];
  motion_t expected_motion [$];
  int steps_sent = 0;
  int steps_accepted = 0;
  int send_idle_pct, recv_idle_pct;
  bit failed = 1'b0;
  int cycles = 0;

  function automatic longint clamp_word(longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    longint unsigned q;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != 0) return PROD_LIMIT;
    q = p[79:16];
    return (q > PROD_LIMIT) ? PROD_LIMIT : q;
  endfunction

  function automatic longint apply_drag(longint v, longint unsigned k);
    longint unsigned m, r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = ((m >> 16) * k + (((m & 64'hFFFF) * k) >> 16)) >> 14;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned submerged_volume(longint y, longint w, longint r);
    longint unsigned ur, pq, fq, full, h, capv, d;
    ur = r;
    pq = (PI_30 + (64'd1 << 13)) >> 14;
    fq = (((4 * PI_30 + 1) / 3) + (64'd1 << 13)) >> 14;
    if (y + r < w) return 0;
    full = fix_mul(fq, fix_mul(fix_mul(ur, ur), ur));
    if (y - r > w) return full;
    d = (y > w) ? y - w : w - y;
    h = ur - d;
    capv = fix_mul(fix_mul(pq, fix_mul(h, h)) / 3, 3 * ur - h);
    if (y > w) return (full > capv) ? full - capv : 0;
    return capv;
  endfunction

  function automatic motion_t advance_sphere(logic [bsm_pkg::DT_W-1:0] dt);
    longint w, fl, rw, px, py, vx, vy, q;
    longint unsigned dv;
    bit hit;
    motion_t m;
    w = settings[bsm_pkg::REG_WATER_LINE];
    fl = settings[bsm_pkg::REG_FLOOR_LINE];
    rw = settings[bsm_pkg::REG_RIGHT_WALL];
    px = sphere_x; py = sphere_y; vx = speed_x; vy = speed_y;
    hit = 0;
    vy = clamp_word(vy + longint'(fix_mul(settings[bsm_pkg::REG_GRAVITY_ACCEL], 64'(dt))));
    dv = fix_mul(fix_mul(settings[bsm_pkg::REG_BUOYANCY_GAIN],
                         submerged_volume(py, w, settings[bsm_pkg::REG_SPHERE_RADIUS])),
                 64'(dt));
    vy = clamp_word(vy - longint'(dv));
    if (py > w) begin
      vx = apply_drag(vx, K_WATER);
      vy = apply_drag(vy, K_WATER);
    end else begin
      vx = apply_drag(vx, K_AIR);
      vy = apply_drag(vy, K_AIR);
    end
    px = clamp_word(px + vx);
    py = clamp_word(py + vy);
    if (px < 0) begin
      if (vx < -65536) hit = 1;
      px = 0;
      vx = -(vx / 6);
    end
    if (px > rw) begin
      if (vx > 65536) hit = 1;
      px = clamp_word(rw);
      vx = -(vx / 6);
    end
    if (py > fl) begin
      if (vy > 65536) hit = 1;
      py = clamp_word(fl);
      q = vy / 6;
      vy = (q < 0) ? q : -q;
    end
    sphere_x = px; sphere_y = py; speed_x = vx; speed_y = vy;
    m.px = bsm_pkg::word_t'(px);
    m.py = bsm_pkg::word_t'(py);
    m.vx = bsm_pkg::word_t'(vx);
    m.vy = bsm_pkg::word_t'(vy);
    m.impact = hit;
    return m;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("buoyant_sphere_motion_step verification failed");
      $finish;
    end
  end

  // driver: present the next step at the falling edge, hold it until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.time_step <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      if (steps_sent == steps_accepted) begin
        if (pending_steps.size() > steps_sent && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.time_step <= pending_steps[steps_sent];
          steps_sent <= steps_sent + 1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on accepted steps, check accepted result beats
  always @(posedge clk) begin
    motion_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_motion.push_back(advance_sphere(in_ch.time_step));
        steps_accepted <= steps_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.px = out_ch.position_x;
        got.py = out_ch.position_y;
        got.vx = out_ch.velocity_x;
        got.vy = out_ch.velocity_y;
        got.impact = out_ch.impact;
        if (expected_motion.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, got);
          failed = 1;
        end else begin
          want = expected_motion.pop_front();
          if (got.px !== want.px) begin
            $display("%0t: position_x expected %0d got %0d", $time, want.px, got.px);
            failed = 1;
          end
          if (got.py !== want.py) begin
            $display("%0t: position_y expected %0d got %0d", $time, want.py, got.py);
            failed = 1;
          end
          if (got.vx !== want.vx) begin
            $display("%0t: velocity_x expected %0d got %0d", $time, want.vx, got.vx);
            failed = 1;
          end
          if (got.vy !== want.vy) begin
            $display("%0t: velocity_y expected %0d got %0d", $time, want.vy, got.vy);
            failed = 1;
          end
          if (got.impact !== want.impact) begin
            $display("%0t: impact expected %0b got %0b", $time, want.impact, got.impact);
            failed = 1;
          end
        end
      end
    end
  end

  task automatic write_setting(bsm_pkg::reg_idx_t idx, longint unsigned v);
    @(negedge clk);
    v = (idx == bsm_pkg::REG_SPHERE_RADIUS) ? (v & 64'h3FFFFF) : (v & 64'h3FFFFFF);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = bsm_pkg::CFG_W'(v);
    settings[idx] = v;
  endtask

  task automatic wait_idle();
    while (steps_sent < pending_steps.size() || steps_sent != steps_accepted ||
           expected_motion.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [bsm_pkg::DT_W-1:0] random_step();
    if ($urandom_range(99) < 70) return bsm_pkg::DT_W'($urandom_range(32'h3000));
    return bsm_pkg::DT_W'($urandom);
  endfunction

  initial begin
    bsm_pkg::reg_idx_t idx;
    longint unsigned v;
    logic [bsm_pkg::DT_W-1:0] directed [20];
    send_idle_pct = 25;
    recv_idle_pct = 88;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = bsm_pkg::REG_WATER_LINE;
    cfg_data = '0;
    settings[bsm_pkg::REG_WATER_LINE] = 64'(bsm_pkg::WATER_LINE_RST);
    settings[bsm_pkg::REG_FLOOR_LINE] = 64'(bsm_pkg::FLOOR_LINE_RST);
    settings[bsm_pkg::REG_RIGHT_WALL] = 64'(bsm_pkg::RIGHT_WALL_RST);
    settings[bsm_pkg::REG_GRAVITY_ACCEL] = 64'(bsm_pkg::GRAVITY_RST);
    settings[bsm_pkg::REG_BUOYANCY_GAIN] = 64'(bsm_pkg::BUOYANCY_RST);
    settings[bsm_pkg::REG_SPHERE_RADIUS] = 64'(bsm_pkg::RADIUS_RST);
    settings[bsm_pkg::REG_START_X] = 64'(bsm_pkg::START_X_RST);
    settings[bsm_pkg::REG_START_Y] = 64'(bsm_pkg::START_Y_RST);
    repeat (2) @(negedge clk);
    rst_n = 1;

    // directed: zero, tiny, huge steps; falls through water, floor hits, saturation
    directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h800000, 24'h000400,
                 24'h001000, 24'h004000, 24'h010000, 24'h010000, 24'h008000,
                 24'h002000, 24'h002000, 24'h7FFFFF, 24'h000001, 24'h555555,
                 24'hAAAAAA, 24'h000800, 24'h000800, 24'h000800, 24'hFFFFFF};
    foreach (directed[i]) pending_steps.push_back(directed[i]);

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      for (int r = 0; r < 8; r++) begin
        idx = bsm_pkg::reg_idx_t'(r);
        case (phase)
          0: v = settings[idx];
          2: v = 0;
          3: v = 64'hFFFFFFFF;
          4: begin
            case (idx)
              bsm_pkg::REG_WATER_LINE:    v = 64'd655360;
              bsm_pkg::REG_FLOOR_LINE:    v = 64'd6553600;
              bsm_pkg::REG_RIGHT_WALL:    v = 64'd3276800;
              bsm_pkg::REG_SPHERE_RADIUS: v = 64'h3FFFFF;
              default:                    v = 64'($urandom_range(32'h0FFFFF));
            endcase
          end
          default: v = 64'($urandom);
        endcase
        write_setting(idx, v);
      end
      @(negedge clk);
      cfg_we = 1'b0;
      send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 88 : 0;
      recv_idle_pct = (phase < 2) ? 88 : (phase < 4) ? 25 : 0;
      repeat (192) pending_steps.push_back(random_step());
    end

    wait_idle();
    if (!failed && expected_motion.size() == 0) begin
      $display("buoyant_sphere_motion_step verification clean");
    end else begin
      $display("buoyant_sphere_motion_step verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/bsm_pkg.sv
src/bsm_in_if.sv
src/bsm_out_if.sv
src/bsm_mul.sv
src/bsm_ctrl.sv
src/bsm_datapath.sv
src/buoyant_sphere_motion_step.sv
tb/buoyant_sphere_motion_step_tb.sv
